### src/rde_pkg.sv
// Shared types and codes for the reversible deque engine.
`default_nettype none

package rde_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_REVERSE = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_TAKE    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ELEMENT  = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_DEL_ERR  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic {
        CTRL_IDLE = 1'b0,
        CTRL_TAKE = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] element;
    } in_item_t;

    typedef struct packed {
        logic [7:0] element_out;
        logic [1:0] status;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_take;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### src/rde_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/rde_ctrl.sv
// Controller state machine: sequences item acceptance and result loading.
`default_nettype none

module rde_ctrl
    import rde_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t dp_status,
    output ctrl_cmd_t       ctrl_cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        in_ready          = 1'b0;
        ctrl_cmd.accept   = 1'b0;
        ctrl_cmd.load_out = 1'b0;
        case (state_reg)
            CTRL_IDLE:
            begin
                in_ready        = 1'b1;
                ctrl_cmd.accept = in_valid;
                if (in_valid && dp_status.is_take)
                begin
                    state_next = CTRL_TAKE;
                end
            end
            CTRL_TAKE:
            begin
                ctrl_cmd.load_out = dp_status.out_free;
                if (dp_status.out_free)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/rde_datapath.sv
// Datapath: pointers, flags, element store and output register.
`default_nettype none

module rde_datapath
    import rde_pkg::*;
#(
    parameter int STORE_DEPTH   = 1024,
    parameter int ELEMENT_WIDTH = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire in_item_t   in_data,
    input  wire ctrl_cmd_t  ctrl_cmd,
    output dp_status_t      dp_status,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data
);

    localparam int PW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [PW:0]   DEPTH_EXT = (PW + 1)'(STORE_DEPTH);
    localparam logic [PW-1:0] LAST_IDX  = PW'(STORE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(STORE_DEPTH);

    logic [PW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;
    logic          del_err_reg, del_err_next;
    logic          ovf_reg, ovf_next;
    status_t       pend_status_reg, pend_status_next;
    logic          pend_last_reg, pend_last_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_reg, out_next;

    logic [PW:0]   app_sum;
    logic [PW:0]   tail_sum;
    logic [PW-1:0] app_idx;
    logic [PW-1:0] tail_idx;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] head_dec;
    logic [CW-1:0] count_dec;

    logic                     ram_we;
    logic [PW-1:0]            ram_waddr;
    logic                     ram_re;
    logic [PW-1:0]            ram_raddr;
    logic [ELEMENT_WIDTH-1:0] ram_wdata;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;

    assign count_dec = count_reg - CW'(1);
    assign app_sum   = {1'b0, head_reg} + {1'b0, count_reg[PW-1:0]};
    assign tail_sum  = {1'b0, head_reg} + {1'b0, count_dec[PW-1:0]};
    assign app_idx   = (app_sum >= DEPTH_EXT) ? PW'(app_sum - DEPTH_EXT) : app_sum[PW-1:0];
    assign tail_idx  = (tail_sum >= DEPTH_EXT) ? PW'(tail_sum - DEPTH_EXT)
                                               : tail_sum[PW-1:0];
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + PW'(1);
    assign head_dec  = (head_reg == '0) ? LAST_IDX : head_reg - PW'(1);
    assign ram_wdata = ELEMENT_WIDTH'(in_data.element);

    assign dp_status.is_take  = (in_data.command == CMD_TAKE);
    assign dp_status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        head_next        = head_reg;
        count_next       = count_reg;
        rev_next         = rev_reg;
        del_err_next     = del_err_reg;
        ovf_next         = ovf_reg;
        pend_status_next = pend_status_reg;
        pend_last_next   = pend_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = app_idx;
        ram_re           = 1'b0;
        ram_raddr        = rev_reg ? tail_idx : head_reg;
        if (ctrl_cmd.accept)
        begin
            case (in_data.command)
                CMD_CLEAR:
                begin
                    head_next    = '0;
                    count_next   = '0;
                    rev_next     = 1'b0;
                    del_err_next = 1'b0;
                    ovf_next     = 1'b0;
                end
                CMD_APPEND:
                begin
                    if (!del_err_reg)
                    begin
                        if (count_reg >= DEPTH_CNT)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (rev_reg)
                            begin
                                head_next = head_dec;
                                ram_waddr = head_dec;
                            end
                        end
                    end
                end
                CMD_REVERSE:
                begin
                    if (!del_err_reg)
                    begin
                        rev_next = !rev_reg;
                    end
                end
                CMD_DELETE:
                begin
                    if (!del_err_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            del_err_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_dec;
                            if (!rev_reg)
                            begin
                                head_next = head_inc;
                            end
                        end
                    end
                end
                CMD_TAKE:
                begin
                    pend_last_next = 1'b0;
                    if (del_err_reg)
                    begin
                        pend_status_next = ST_DEL_ERR;
                    end
                    else if (ovf_reg)
                    begin
                        pend_status_next = ST_OVERFLOW;
                    end
                    else if (count_reg == '0)
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pend_status_next = ST_ELEMENT;
                        pend_last_next   = (count_reg == CW'(1));
                        ram_re           = 1'b1;
                        count_next       = count_dec;
                        if (!rev_reg)
                        begin
                            head_next = head_inc;
                        end
                    end
                end
                default:
                begin
                    head_next = head_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl_cmd.load_out)
        begin
            out_valid_next       = 1'b1;
            out_next.status      = pend_status_reg;
            out_next.last        = pend_last_reg;
            out_next.element_out = (pend_status_reg == ST_ELEMENT) ? 8'(ram_rdata) : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            del_err_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            del_err_reg   <= del_err_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_last_reg   <= pend_last_next;
        out_reg         <= out_next;
    end

    rde_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

### src/reversible_deque_engine_core.sv
// Top level of the reversible deque engine: controller plus datapath.
//
// Input channel in_valid/in_ready/in_data carries one command item:
// clear, append, reverse, delete front or take front. Output channel
// out_valid/out_ready/out_data carries one result item per take only.
// Clear, append, reverse and delete can be issued back to back. A take
// holds the block in the TAKE state until its result is loaded: the store
// has a registered read port, so the element is read in the accept cycle
// and loaded into the output register in the TAKE state once it is free.
// A full output register does not block non-take commands; after a take
// the next item waits with in_ready low until the output register can be loaded.
// Reset clears pointers, count, view direction and both sticky flags and
// empties the output register; store contents are left as they are and
// no clearing pass is needed. When the receiver stalls, the result holds
// in the output register unchanged.
`default_nettype none

module reversible_deque_engine_core
    import rde_pkg::*;
#(
    parameter int STORE_DEPTH   = 1024,
    parameter int ELEMENT_WIDTH = 8
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_data
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    rde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    rde_datapath #(
        .STORE_DEPTH   (STORE_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctrl_cmd  (ctrl_cmd),
        .dp_status (dp_status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### test/testbench.sv
// Testbench for reversible_deque_engine_core: queued command driver, result monitor and checker.
`timescale 1ns / 1ps

module testbench;
    import rde_pkg::*;

    localparam int DEPTH = 1024;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS = 70;
    localparam int MAX_REPORTS = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        mismatches = 0;

    logic [7:0]  deque_store [DEPTH];
    logic [9:0]  deque_head = '0;
    logic [10:0] deque_count = '0;
    logic        view_reversed = 1'b0;
    logic        del_sticky = 1'b0;
    logic        ovf_sticky = 1'b0;

    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_span = 0;
    int          stall_mode = 0;
    logic [15:0] stall_pattern = '1;
    logic [3:0]  stall_phase = '0;

    reversible_deque_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] take_view_front();
        logic [7:0] v;
        if (view_reversed)
        begin
            v = deque_store[deque_head + deque_count[9:0] - 10'd1];
        end
        else
        begin
            v = deque_store[deque_head];
            deque_head = deque_head + 10'd1;
        end
        deque_count = deque_count - 11'd1;
        return v;
    endfunction

    function automatic void apply_deque_command(in_item_t it);
        out_item_t r;
        r = '0;
        case (it.command)
            CMD_CLEAR:
            begin
                deque_head = '0;
                deque_count = '0;
                view_reversed = 1'b0;
                del_sticky = 1'b0;
                ovf_sticky = 1'b0;
            end
            CMD_APPEND:
            begin
                if (!del_sticky)
                begin
                    if (deque_count >= DEPTH)
                    begin
                        ovf_sticky = 1'b1;
                    end
                    else
                    begin
                        if (view_reversed)
                        begin
                            deque_head = deque_head - 10'd1;
                            deque_store[deque_head] = it.element;
                        end
                        else
                        begin
                            deque_store[deque_head + deque_count[9:0]] = it.element;
                        end
                        deque_count = deque_count + 11'd1;
                    end
                end
            end
            CMD_REVERSE:
            begin
                if (!del_sticky)
                    view_reversed = ~view_reversed;
            end
            CMD_DELETE:
            begin
                if (!del_sticky)
                begin
                    if (deque_count == 0)
                        del_sticky = 1'b1;
                    else
                        void'(take_view_front());
                end
            end
            CMD_TAKE:
            begin
                if (del_sticky)
                    r.status = ST_DEL_ERR;
                else if (ovf_sticky)
                    r.status = ST_OVERFLOW;
                else if (deque_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.element_out = take_view_front();
                    r.status = ST_ELEMENT;
                    r.last = (deque_count == 0);
                end
                expected_results = {expected_results, r};
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic queue_command(logic [2:0] c, logic [7:0] e);
        in_item_t it;
        it.command = c;
        it.element = e;
        pending_items = {pending_items, it};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_deque_command(in_data);
            if (in_valid && !in_ready)
            begin
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                in_data <= pending_items[0];
                pending_items.delete(0);
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: element_out=%0d status=%0d last=%0d",
                                 out_data.element_out, out_data.status, out_data.last);
                end
                else
                begin
                    out_item_t want;
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (want.element_out !== out_data.element_out ||
                        want.status !== out_data.status || want.last !== out_data.last)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.element_out, want.status, want.last,
                                     out_data.element_out, out_data.status, out_data.last);
                    end
                end
            end
            if (stall_span == 0)
            begin
                stall_span <= $urandom_range(20, 200);
                stall_mode <= $urandom_range(0, 2);
                stall_pattern <= 16'($urandom) | 16'h0001;
            end
            else
            begin
                stall_span <= stall_span - 1;
            end
            stall_phase <= stall_phase + 4'd1;
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= stall_pattern[stall_phase];
                default: out_ready <= stall_pattern[stall_phase] & ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        int         counted;
        int         shadow_count;
        logic       shadow_err;
        int         pick;
        logic [2:0] c;

        // directed: edge values, every command, empty take, last flag, delete error
        queue_command(CMD_TAKE, 8'h00);
        queue_command(CMD_APPEND, 8'h00);
        queue_command(CMD_APPEND, 8'hFF);
        queue_command(CMD_APPEND, 8'hA5);
        queue_command(CMD_TAKE, 8'hFF);
        queue_command(CMD_REVERSE, 8'h00);
        queue_command(CMD_TAKE, 8'h00);
        queue_command(CMD_TAKE, 8'h00);
        queue_command(CMD_REVERSE, 8'hFF);
        queue_command(CMD_APPEND, 8'h01);
        queue_command(CMD_APPEND, 8'h02);
        queue_command(CMD_APPEND, 8'h03);
        queue_command(CMD_REVERSE, 8'h00);
        queue_command(CMD_DELETE, 8'hFF);
        queue_command(CMD_TAKE, 8'h00);
        queue_command(CMD_UNUSED_LO, 8'hFF);
        queue_command(CMD_UNUSED_MID, 8'h5A);
        queue_command(CMD_UNUSED_HI, 8'hFF);
        queue_command(CMD_DELETE, 8'h00);
        queue_command(CMD_DELETE, 8'h00);
        queue_command(CMD_APPEND, 8'h55);
        queue_command(CMD_REVERSE, 8'h00);
        queue_command(CMD_TAKE, 8'h00);
        queue_command(CMD_CLEAR, 8'hFF);
        queue_command(CMD_TAKE, 8'h00);

        // fill to capacity across the wrap point, then overflow
        queue_command(CMD_CLEAR, 8'h00);
        for (int i = 0; i < 7; i++)
            queue_command(CMD_APPEND, 8'($urandom_range(0, 255)));
        for (int i = 0; i < 7; i++)
            queue_command(CMD_TAKE, 8'h00);
        for (int i = 0; i < 600; i++)
            queue_command(CMD_APPEND, 8'($urandom_range(0, 255)));
        queue_command(CMD_REVERSE, 8'h00);
        for (int i = 0; i < DEPTH - 600; i++)
            queue_command(CMD_APPEND, 8'($urandom_range(0, 255)));
        queue_command(CMD_TAKE, 8'h00);
        queue_command(CMD_APPEND, 8'hC3);
        for (int i = 0; i < 3; i++)
            queue_command(CMD_APPEND, 8'($urandom_range(0, 255)));
        queue_command(CMD_TAKE, 8'h00);
        queue_command(CMD_DELETE, 8'h00);
        queue_command(CMD_DELETE, 8'h00);
        queue_command(CMD_REVERSE, 8'h00);
        queue_command(CMD_APPEND, 8'h3C);
        queue_command(CMD_TAKE, 8'h00);
        queue_command(CMD_CLEAR, 8'h00);
        queue_command(CMD_TAKE, 8'h00);

        // random command streams, steered away from endless delete errors
        counted = 0;
        shadow_count = 0;
        shadow_err = 1'b0;
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3 || (shadow_err && pick < 30))
                c = CMD_CLEAR;
            else if (pick < 45)
                c = CMD_APPEND;
            else if (pick < 54)
                c = CMD_REVERSE;
            else if (pick < 64)
                c = CMD_DELETE;
            else if (pick < 95)
                c = CMD_TAKE;
            else
                c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
            if (c == CMD_DELETE && shadow_count == 0 && $urandom_range(0, 4) != 0)
                c = CMD_APPEND;
            case (c)
                CMD_CLEAR:
                begin
                    shadow_count = 0;
                    shadow_err = 1'b0;
                end
                CMD_APPEND:
                begin
                    if (!shadow_err)
                        shadow_count = shadow_count + 1;
                end
                CMD_DELETE, CMD_TAKE:
                begin
                    if (shadow_count > 0 && !shadow_err)
                        shadow_count = shadow_count - 1;
                    else if (c == CMD_DELETE)
                        shadow_err = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (c <= CMD_TAKE)
                counted = counted + 1;
            queue_command(c, 8'($urandom_range(0, 255)));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
src/rde_pkg.sv
src/rde_ram.sv
src/rde_ctrl.sv
src/rde_datapath.sv
src/reversible_deque_engine_core.sv
test/testbench.sv
